>>> src/mcrq_pkg.sv
// mcrq_pkg: command, status and state codes for the multichannel ring queue
// with duplicate-address check. No dependencies.
`default_nettype none

package mcrq_pkg;

  localparam int CMD_W    = 3;
  localparam int CHAN_W   = 8;
  localparam int SIZE_W   = 7;
  localparam int FRAME_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;

  // commands
  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STAT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSTP  = 3'd6;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CHANNEL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_OPEN    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE    = 3'd5;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_OUTER,
    S_LOAD,
    S_INNER,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

>>> src/mcrq_entry_ram.sv
// mcrq_entry_ram: entry store, one write port and one read port with
// registered read data. Depends on nothing.
`default_nettype none

module mcrq_entry_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 96
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/multichannel_ring_queue_dup_check.sv
// multichannel_ring_queue_dup_check: per-channel circular frame queues held
// in one entry memory, with a pairwise duplicate-address scan.
// Depends on mcrq_pkg and mcrq_entry_ram.
//
// Usage: a request is taken when start is high and busy is low. Its one
// result appears for exactly one cycle with done high; the receiver cannot
// hold it off, so it must take it in that cycle.
// Path from the accepting edge to the result:
//   status, open, close, pointer reset and every failed command: S_FIN only
//   peek: S_HEAD (one entry-memory read of the head), then S_FIN
//   push and pop: the duplicate scan compares every pair of held entries
//   through the single read port of the entry memory, in S_OUTER, S_LOAD
//   and S_INNER; a pop first reads the head in S_HEAD, and a pop that
//   leaves nothing goes from S_OUTER straight to S_FIN.
//   The scan stops early at the first repeated frame address.
// busy rises at the accepting edge and falls as done rises, so one request
// is in work at a time and the next can be taken at the result edge.
// Reset (rst, synchronous) closes every channel and clears its pointers;
// the entry memory is not cleared, entries are only read once written.
`default_nettype none

module multichannel_ring_queue_dup_check
  import mcrq_pkg::*;
#(
  parameter int CHANNELS         = 4,
  parameter int MAX_SLOTS        = 64,
  parameter int ENTRY_INFO_WIDTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [CMD_W-1:0]            command,
  input  wire logic [CHAN_W-1:0]           channel,
  input  wire logic [SIZE_W-1:0]           slot_count,
  input  wire logic [FRAME_W-1:0]          frame_addr,
  input  wire logic [ENTRY_INFO_WIDTH-1:0] entry_info,
  output logic                             done,
  output logic [STATUS_W-1:0]              status,
  output logic [FRAME_W-1:0]               out_frame_addr,
  output logic [ENTRY_INFO_WIDTH-1:0]      out_entry_info,
  output logic [COUNT_W-1:0]               active_count,
  output logic [COUNT_W-1:0]               free_count,
  output logic                             duplicate_found
);

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW    = $clog2(MAX_SLOTS);
  localparam int SW    = $clog2(MAX_SLOTS + 1);
  localparam int DEPTH = CHANNELS * MAX_SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = FRAME_W + ENTRY_INFO_WIDTH;

  // step an index round the ring of n slots
  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] x,
                                              input logic [SW-1:0] n);
    logic [SW:0] p;
    p = (SW+1)'(x) + (SW+1)'(1);
    return (p >= {1'b0, n}) ? '0 : IW'(p);
  endfunction

  function automatic logic [AW-1:0] ent_addr(input logic [CW-1:0] c,
                                             input logic [IW-1:0] x);
    return AW'(AW'(c) * AW'(MAX_SLOTS) + AW'(x));
  endfunction

  // channel table
  logic          chan_open [CHANNELS];
  logic [SW-1:0] chan_slots [CHANNELS];
  logic [IW-1:0] chan_wr [CHANNELS];
  logic [IW-1:0] chan_rd [CHANNELS];

  // request and scan registers
  state_t                      state, state_next;
  logic [CW-1:0]               ch_q, ch_q_next;
  logic                        valid_q, valid_q_next;
  logic [CMD_W-1:0]            cmd_q, cmd_q_next;
  logic [STATUS_W-1:0]         st_q, st_q_next;
  logic [FRAME_W-1:0]          oaddr_q, oaddr_q_next;
  logic [ENTRY_INFO_WIDTH-1:0] oinfo_q, oinfo_q_next;
  logic                        dup_q, dup_q_next;
  logic [IW-1:0]               i_q, i_q_next;
  logic [IW-1:0]               j_q, j_q_next;
  logic [IW-1:0]               end_q, end_q_next;
  logic [SW-1:0]               n_q, n_q_next;
  logic [FRAME_W-1:0]          ref_q, ref_q_next;
  logic                        pend_q, pend_q_next;

  // one channel-table update per cycle
  logic          upd;
  logic [CW-1:0] upd_ch;
  logic          upd_open;
  logic [SW-1:0] upd_slots;
  logic [IW-1:0] upd_wr;
  logic [IW-1:0] upd_rd;

  // memory ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  // request view of the addressed channel
  logic          in_valid;
  logic [CW-1:0] in_ch;
  logic          cur_open;
  logic [SW-1:0] cur_n;
  logic [IW-1:0] cur_wr;
  logic [IW-1:0] cur_rd;
  logic [IW-1:0] cur_wr_nx;
  logic [IW-1:0] cur_rd_nx;

  // counts at the end of a request
  logic          fin_open;
  logic [SW-1:0] fin_n;
  logic [SW-1:0] fin_active;
  logic [SW:0]   fin_free;
  logic          fin;

  assign in_valid  = channel < CHAN_W'(CHANNELS);
  assign in_ch     = CW'(channel);
  assign cur_open  = chan_open[in_ch];
  assign cur_n     = chan_slots[in_ch];
  assign cur_wr    = chan_wr[in_ch];
  assign cur_rd    = chan_rd[in_ch];
  assign cur_wr_nx = next_slot(cur_wr, cur_n);
  assign cur_rd_nx = next_slot(cur_rd, cur_n);
  assign busy      = (state != S_IDLE);

  mcrq_entry_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (DW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // active and free counts of the finished channel
  always_comb begin
    fin_open = chan_open[ch_q];
    fin_n    = chan_slots[ch_q];
    if (!fin_open) begin
      fin_active = '0;
    end else if (chan_wr[ch_q] >= chan_rd[ch_q]) begin
      fin_active = SW'(chan_wr[ch_q]) - SW'(chan_rd[ch_q]);
    end else begin
      fin_active = SW'(chan_wr[ch_q]) + fin_n - SW'(chan_rd[ch_q]);
    end
    if (!fin_open || fin_n == '0 || ({1'b0, fin_active} + 1'b1) > {1'b0, fin_n}) begin
      fin_free = '0;
    end else begin
      fin_free = {1'b0, fin_n} - {1'b0, fin_active} - 1'b1;
    end
  end

  // sequencer: request decode, head read and pairwise scan
  always_comb begin
    state_next   = state;
    ch_q_next    = ch_q;
    valid_q_next = valid_q;
    cmd_q_next   = cmd_q;
    st_q_next    = st_q;
    oaddr_q_next = oaddr_q;
    oinfo_q_next = oinfo_q;
    dup_q_next   = dup_q;
    i_q_next     = i_q;
    j_q_next     = j_q;
    end_q_next   = end_q;
    n_q_next     = n_q;
    ref_q_next   = ref_q;
    pend_q_next  = pend_q;
    upd          = 1'b0;
    upd_ch       = in_ch;
    upd_open     = cur_open;
    upd_slots    = cur_n;
    upd_wr       = cur_wr;
    upd_rd       = cur_rd;
    ram_we       = 1'b0;
    ram_waddr    = ent_addr(in_ch, cur_wr);
    ram_wdata    = {entry_info, frame_addr};
    ram_raddr    = ent_addr(ch_q, i_q);
    fin          = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ch_q_next    = in_ch;
          valid_q_next = in_valid;
          cmd_q_next   = command;
          st_q_next    = ST_OK;
          oaddr_q_next = '0;
          oinfo_q_next = '0;
          dup_q_next   = 1'b0;
          state_next   = S_FIN;
          ram_raddr    = ent_addr(in_ch, cur_rd);
          if (!in_valid) begin
            st_q_next = ST_BAD_CHANNEL;
          end else begin
            unique case (command)
              CMD_PUSH: begin
                if (!cur_open) begin
                  st_q_next = ST_NOT_OPEN;
                end else if (cur_wr_nx == cur_rd) begin
                  st_q_next = ST_FULL;
                end else begin
                  ram_we     = 1'b1;
                  upd        = 1'b1;
                  upd_wr     = cur_wr_nx;
                  i_q_next   = cur_rd;
                  end_q_next = cur_wr_nx;
                  n_q_next   = cur_n;
                  state_next = S_OUTER;
                end
              end
              CMD_POP, CMD_PEEK: begin
                if (!cur_open) begin
                  st_q_next = ST_NOT_OPEN;
                end else if (cur_wr == cur_rd) begin
                  st_q_next = ST_EMPTY;
                end else begin
                  state_next = S_HEAD;
                  if (command == CMD_POP) begin
                    upd        = 1'b1;
                    upd_rd     = cur_rd_nx;
                    i_q_next   = cur_rd_nx;
                    end_q_next = cur_wr;
                    n_q_next   = cur_n;
                  end
                end
              end
              CMD_OPEN: begin
                if (slot_count == '0 || {1'b0, slot_count} > (SIZE_W+1)'(MAX_SLOTS)) begin
                  st_q_next = ST_BAD_SIZE;
                end else begin
                  upd       = 1'b1;
                  upd_open  = 1'b1;
                  upd_slots = SW'(slot_count);
                  upd_wr    = '0;
                  upd_rd    = '0;
                end
              end
              CMD_CLOSE: begin
                upd       = 1'b1;
                upd_open  = 1'b0;
                upd_slots = '0;
                upd_wr    = '0;
                upd_rd    = '0;
              end
              CMD_RSTP: begin
                upd    = 1'b1;
                upd_wr = '0;
                upd_rd = '0;
              end
              default: begin
                if (!cur_open) begin
                  st_q_next = ST_NOT_OPEN;
                end
              end
            endcase
          end
        end
      end
      S_HEAD: begin
        oaddr_q_next = ram_rdata[FRAME_W-1:0];
        oinfo_q_next = ram_rdata[DW-1:FRAME_W];
        state_next   = (cmd_q == CMD_POP) ? S_OUTER : S_FIN;
      end
      S_OUTER: begin
        ram_raddr  = ent_addr(ch_q, i_q);
        state_next = (i_q == end_q) ? S_FIN : S_LOAD;
      end
      S_LOAD: begin
        ref_q_next  = ram_rdata[FRAME_W-1:0];
        j_q_next    = next_slot(i_q, n_q);
        pend_q_next = 1'b0;
        state_next  = S_INNER;
      end
      S_INNER: begin
        ram_raddr = ent_addr(ch_q, j_q);
        if (pend_q && ram_rdata[FRAME_W-1:0] == ref_q) begin
          dup_q_next = 1'b1;
          state_next = S_FIN;
        end else if (j_q != end_q) begin
          pend_q_next = 1'b1;
          j_q_next    = next_slot(j_q, n_q);
        end else if (pend_q) begin
          pend_q_next = 1'b0;
        end else begin
          i_q_next   = next_slot(i_q, n_q);
          state_next = S_OUTER;
        end
      end
      S_FIN: begin
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  // channel table registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        chan_open[c]  <= 1'b0;
        chan_slots[c] <= '0;
        chan_wr[c]    <= '0;
        chan_rd[c]    <= '0;
      end
    end else if (upd) begin
      chan_open[upd_ch]  <= upd_open;
      chan_slots[upd_ch] <= upd_slots;
      chan_wr[upd_ch]    <= upd_wr;
      chan_rd[upd_ch]    <= upd_rd;
    end
  end

  // request payload and scan registers
  always_ff @(posedge clk) begin
    ch_q    <= ch_q_next;
    valid_q <= valid_q_next;
    cmd_q   <= cmd_q_next;
    st_q    <= st_q_next;
    oaddr_q <= oaddr_q_next;
    oinfo_q <= oinfo_q_next;
    dup_q   <= dup_q_next;
    i_q     <= i_q_next;
    j_q     <= j_q_next;
    end_q   <= end_q_next;
    n_q     <= n_q_next;
    ref_q   <= ref_q_next;
    pend_q  <= pend_q_next;
  end

  // result registers
  always_ff @(posedge clk) begin
    if (fin) begin
      status          <= st_q;
      out_frame_addr  <= oaddr_q;
      out_entry_info  <= oinfo_q;
      duplicate_found <= dup_q;
      active_count    <= valid_q ? COUNT_W'(fin_active) : '0;
      free_count      <= valid_q ? COUNT_W'(fin_free) : '0;
    end
  end

endmodule

`default_nettype wire

>>> src/mcrq_checker.sv
// mcrq_checker: port-level checks of the ring queue block, bound to the top
// level. Depends on mcrq_pkg.
`default_nettype none

module mcrq_checker
  import mcrq_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [COUNT_W-1:0]  active_count,
  input wire logic [COUNT_W-1:0]  free_count,
  input wire logic                duplicate_found
);

  // a taken request keeps the block busy
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low after a request was taken");

  // never two results in a row
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // a bad channel reports no counts
  a_bad_chan_counts: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_BAD_CHANNEL |-> active_count == '0 && free_count == '0)
    else $error("counts reported for a bad channel");

  // duplicates are only flagged after a successful request
  a_dup_only_ok: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> !duplicate_found)
    else $error("duplicate flagged on a failed request");

endmodule

bind multichannel_ring_queue_dup_check mcrq_checker u_mcrq_checker (.*);

`default_nettype wire

>>> tb/tb_multichannel_ring_queue_dup_check.sv
// tb_multichannel_ring_queue_dup_check: self-checking bench for the ring queue
// with duplicate-address check. Depends on mcrq_pkg and the block's RTL.
`default_nettype none

module tb_multichannel_ring_queue_dup_check;
  import mcrq_pkg::*;

  localparam int CHANNELS   = 4;
  localparam int MAX_SLOTS  = 64;
  localparam int INFO_W     = 64;
  localparam int RAND_ITEMS = 1600;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
  localparam logic [FRAME_W-1:0] ADDR_STEP = 32'h80;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [CHAN_W-1:0]  chan;
    logic [SIZE_W-1:0]  size;
    logic [FRAME_W-1:0] faddr;
    logic [INFO_W-1:0]  info;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] st;
    logic [FRAME_W-1:0]  faddr;
    logic [INFO_W-1:0]   info;
    logic [COUNT_W-1:0]  active;
    logic [COUNT_W-1:0]  free;
    logic                dup;
  } reply_t;

  logic clk, rst, start, busy, done, duplicate_found;
  logic [CMD_W-1:0] command;
  logic [CHAN_W-1:0] channel;
  logic [SIZE_W-1:0] slot_count;
  logic [FRAME_W-1:0] frame_addr, out_frame_addr;
  logic [INFO_W-1:0] entry_info, out_entry_info;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0] active_count, free_count;

  multichannel_ring_queue_dup_check #(
    .CHANNELS(CHANNELS), .MAX_SLOTS(MAX_SLOTS), .ENTRY_INFO_WIDTH(INFO_W)
  ) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .channel(channel), .slot_count(slot_count), .frame_addr(frame_addr),
    .entry_info(entry_info), .done(done), .status(status),
    .out_frame_addr(out_frame_addr), .out_entry_info(out_entry_info),
    .active_count(active_count), .free_count(free_count),
    .duplicate_found(duplicate_found)
  );

  // queue shadow state
  bit q_open [CHANNELS];
  int q_slots [CHANNELS];
  int q_wr [CHANNELS];
  int q_rd [CHANNELS];
  logic [FRAME_W-1:0] q_addr [CHANNELS*MAX_SLOTS];
  logic [INFO_W-1:0] q_info [CHANNELS*MAX_SLOTS];

  request_t requests_pending[$];
  reply_t replies_due[$];
  int errors = 0;
  int gap = 0;
  bit burst = 0;
  int idle_cycles = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int next_slot(int idx, int n);
    return (idx + 1 >= n) ? 0 : idx + 1;
  endfunction

  function automatic int held(int ch);
    if (!q_open[ch]) return 0;
    return (q_wr[ch] >= q_rd[ch]) ? q_wr[ch] - q_rd[ch] : q_wr[ch] + q_slots[ch] - q_rd[ch];
  endfunction

  function automatic int spare(int ch);
    int a;
    a = held(ch);
    if (!q_open[ch] || q_slots[ch] == 0 || a + 1 > q_slots[ch]) return 0;
    return q_slots[ch] - 1 - a;
  endfunction

  // any repeated frame address among the held entries
  function automatic bit addr_repeat(int ch);
    logic [FRAME_W-1:0] seen[$];
    int rd;
    bit hit;
    rd = q_rd[ch];
    hit = 0;
    for (int g = 0; rd != q_wr[ch] && g < MAX_SLOTS; g++) begin
      logic [FRAME_W-1:0] a;
      a = q_addr[ch*MAX_SLOTS + rd % MAX_SLOTS];
      foreach (seen[k]) if (seen[k] == a) hit = 1;
      seen.push_back(a);
      rd = next_slot(rd, q_slots[ch]);
    end
    return hit;
  endfunction

  // advance the shadow queues by one request and return its reply
  function automatic reply_t queue_reply(request_t r);
    reply_t e;
    int ch, n, nx, idx;
    e = '{ST_OK, '0, '0, '0, '0, 1'b0};
    if (r.chan >= CHANNELS) begin
      e.st = ST_BAD_CHANNEL;
      return e;
    end
    ch = r.chan;
    n = q_slots[ch];
    case (r.cmd)
      CMD_PUSH: begin
        if (!q_open[ch]) e.st = ST_NOT_OPEN;
        else begin
          nx = next_slot(q_wr[ch], n);
          if (nx == q_rd[ch]) e.st = ST_FULL;
          else begin
            idx = ch*MAX_SLOTS + q_wr[ch] % MAX_SLOTS;
            q_addr[idx] = r.faddr;
            q_info[idx] = r.info;
            q_wr[ch] = nx;
            e.dup = addr_repeat(ch);
          end
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (!q_open[ch]) e.st = ST_NOT_OPEN;
        else if (held(ch) == 0) e.st = ST_EMPTY;
        else begin
          idx = ch*MAX_SLOTS + q_rd[ch] % MAX_SLOTS;
          e.faddr = q_addr[idx];
          e.info = q_info[idx];
          if (r.cmd == CMD_POP) begin
            q_rd[ch] = next_slot(q_rd[ch], n);
            e.dup = addr_repeat(ch);
          end
        end
      end
      CMD_OPEN: begin
        if (r.size == 0 || r.size > MAX_SLOTS) e.st = ST_BAD_SIZE;
        else begin
          q_open[ch] = 1;
          q_slots[ch] = r.size;
          q_wr[ch] = 0;
          q_rd[ch] = 0;
        end
      end
      CMD_CLOSE: begin
        q_open[ch] = 0;
        q_slots[ch] = 0;
        q_wr[ch] = 0;
        q_rd[ch] = 0;
      end
      CMD_RSTP: begin
        q_wr[ch] = 0;
        q_rd[ch] = 0;
      end
      default: if (!q_open[ch]) e.st = ST_NOT_OPEN;
    endcase
    e.active = COUNT_W'(held(ch));
    e.free = COUNT_W'(spare(ch));
    return e;
  endfunction

  function automatic request_t mk(logic [CMD_W-1:0] c, int ch, int sz,
                                  logic [FRAME_W-1:0] fa, logic [INFO_W-1:0] inf);
    request_t r;
    r.cmd = c; r.chan = CHAN_W'(ch); r.size = SIZE_W'(sz); r.faddr = fa; r.info = inf;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int p;
    p = $urandom_range(99);
    if (p < 8) r.cmd = CMD_OPEN;
    else if (p < 10) r.cmd = CMD_CLOSE;
    else if (p < 12) r.cmd = CMD_RSTP;
    else if (p < 15) r.cmd = CMD_STAT;
    else if (p < 16) r.cmd = CMD_SPARE;
    else if (p < 50) r.cmd = CMD_PUSH;
    else if (p < 80) r.cmd = CMD_POP;
    else r.cmd = CMD_PEEK;
    r.chan = ($urandom_range(19) == 0) ? CHAN_W'($urandom_range(255, CHANNELS))
                                       : CHAN_W'($urandom_range(CHANNELS-1));
    p = $urandom_range(99);
    if (p < 70) r.size = SIZE_W'($urandom_range(8, 2));
    else if (p < 80) r.size = SIZE_W'(1);
    else if (p < 85) r.size = SIZE_W'(0);
    else if (p < 90) r.size = SIZE_W'($urandom_range(127, MAX_SLOTS+1));
    else if (p < 92) r.size = SIZE_W'(MAX_SLOTS);
    else r.size = SIZE_W'($urandom_range(20, 9));
    // small address pool so duplicates are common
    r.faddr = ($urandom_range(9) < 7) ? ADDR_STEP * $urandom_range(15) : $urandom;
    r.info = {$urandom, $urandom};
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (burst) return 0;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      command <= CMD_STAT;
      channel <= '0;
      slot_count <= '0;
      frame_addr <= '0;
      entry_info <= '0;
    end else begin
      request_t cur;
      if (start && !busy) begin
        cur.cmd = command; cur.chan = channel; cur.size = slot_count;
        cur.faddr = frame_addr; cur.info = entry_info;
        replies_due.push_back(queue_reply(cur));
      end
      if ($urandom_range(49) == 0) burst = ~burst;
      if (!start || !busy) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (requests_pending.size() > 0) begin
          cur = requests_pending.pop_front();
          command <= cur.cmd;
          channel <= cur.chan;
          slot_count <= cur.size;
          frame_addr <= cur.faddr;
          entry_info <= cur.info;
          start <= 1'b1;
          gap = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      reply_t e;
      if (replies_due.size() == 0) begin
        $display("%0t: result with none expected: status %0d", $time, status);
        errors++;
      end else begin
        e = replies_due.pop_front();
        if (status !== e.st) begin
          $display("%0t: status exp %0d got %0d", $time, e.st, status);
          errors++;
        end
        if (out_frame_addr !== e.faddr) begin
          $display("%0t: frame addr exp %h got %h", $time, e.faddr, out_frame_addr);
          errors++;
        end
        if (out_entry_info !== e.info) begin
          $display("%0t: entry info exp %h got %h", $time, e.info, out_entry_info);
          errors++;
        end
        if (active_count !== e.active) begin
          $display("%0t: active exp %0d got %0d", $time, e.active, active_count);
          errors++;
        end
        if (free_count !== e.free) begin
          $display("%0t: free exp %0d got %0d", $time, e.free, free_count);
          errors++;
        end
        if (duplicate_found !== e.dup) begin
          $display("%0t: duplicate exp %0b got %0b", $time, e.dup, duplicate_found);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request taken and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("multichannel_ring_queue_dup_check verification failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    // directed: size limits, full and empty, duplicates, bad channel
    requests_pending.push_back(mk(CMD_PUSH, 0, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_STAT, 0, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_POP, 1, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_OPEN, 0, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_OPEN, 0, 65, 32'h0, '0));
    requests_pending.push_back(mk(CMD_OPEN, 0, 127, 32'h0, '0));
    requests_pending.push_back(mk(CMD_OPEN, 0, 3, 32'h0, '0));
    requests_pending.push_back(mk(CMD_POP, 0, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_PEEK, 0, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_PUSH, 0, 0, 32'hFFFF_FFFF, '1));
    requests_pending.push_back(mk(CMD_PUSH, 0, 0, 32'hFFFF_FFFF, 64'h0));
    requests_pending.push_back(mk(CMD_PUSH, 0, 0, 32'h0, 64'h5A5A_5A5A_A5A5_A5A5));
    requests_pending.push_back(mk(CMD_PEEK, 0, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_POP, 0, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_POP, 0, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_OPEN, 1, 1, 32'h0, '0));
    requests_pending.push_back(mk(CMD_PUSH, 1, 0, ADDR_STEP, '0));
    requests_pending.push_back(mk(CMD_OPEN, 2, MAX_SLOTS, 32'h0, '0));
    requests_pending.push_back(mk(CMD_PUSH, 2, 0, ADDR_STEP, '1));
    requests_pending.push_back(mk(CMD_OPEN, 2, 5, 32'h0, '0));
    requests_pending.push_back(mk(CMD_RSTP, 3, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_CLOSE, 3, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_CLOSE, 1, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_SPARE, 0, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_STAT, 8'hFF, 0, 32'h0, '0));
    requests_pending.push_back(mk(CMD_OPEN, 4, 3, 32'h0, '0));
    for (int i = 0; i < RAND_ITEMS; i++) requests_pending.push_back(random_request());

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // checked mid-cycle, once the driver's updates have settled
    while (requests_pending.size() > 0 || start || replies_due.size() > 0)
      @(negedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("multichannel_ring_queue_dup_check verification clean");
    else $display("multichannel_ring_queue_dup_check verification failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/mcrq_pkg.sv
src/mcrq_entry_ram.sv
src/multichannel_ring_queue_dup_check.sv
src/mcrq_checker.sv
tb/tb_multichannel_ring_queue_dup_check.sv
